### design/b64e_pkg.sv
// Package for the base64 stream encoder: the queue entry type, character
// constants and the symbol-to-ASCII mapping. No dependencies.
`timescale 1ns / 1ps

package b64e_pkg;

  localparam int unsigned SymW  = 6;
  localparam int unsigned CharW = 7;
  localparam int unsigned Slots = 4;

  localparam logic [CharW-1:0] ChUpperA = 7'h41;  // 'A'
  localparam logic [CharW-1:0] ChLowerA = 7'h61;  // 'a'
  localparam logic [CharW-1:0] ChDigit0 = 7'h30;  // '0'
  localparam logic [CharW-1:0] ChPlus   = 7'h2B;  // '+'
  localparam logic [CharW-1:0] ChSlash  = 7'h2F;  // '/'
  localparam logic [CharW-1:0] ChMinus  = 7'h2D;  // '-'
  localparam logic [CharW-1:0] ChUnder  = 7'h5F;  // '_'
  localparam logic [CharW-1:0] ChPad    = 7'h3D;  // '='

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  // One queue entry holds every character a single input byte produces.
  typedef struct packed {
    logic [1:0]                     last_idx;  // number of characters minus one
    logic [Slots-1:0][SymW-1:0]     sym;
    logic [Slots-1:0]               pad;       // slot is a padding sign
    logic                           eom;       // entry ends the message
  } entry_t;

  function automatic logic [CharW-1:0] sym_to_ascii(input logic [SymW-1:0] sym,
                                                    input logic url_safe);
    logic [CharW-1:0] s;
    s = {1'b0, sym};
    if (sym < 6'd26) begin
      sym_to_ascii = ChUpperA + s;
    end else if (sym < 6'd52) begin
      sym_to_ascii = ChLowerA + (s - 7'd26);
    end else if (sym < 6'd62) begin
      sym_to_ascii = ChDigit0 + (s - 7'd52);
    end else if (sym == 6'd62) begin
      sym_to_ascii = url_safe ? ChMinus : ChPlus;
    end else begin
      sym_to_ascii = url_safe ? ChUnder : ChSlash;
    end
  endfunction

endpackage

### design/base64_stream_encoder_top.sv
// Top level of the streaming base64 encoder. Ties the byte front end, the
// entry queue and the character back end together. Depends on b64e_pkg.
`timescale 1ns / 1ps

// Usage:
// The input channel carries one message byte per word (data_byte) with
// end_of_message set on the final byte. The block raises in_stall only when
// its internal queue of pending bytes is full.
// The output channel carries one ASCII character per word (out_char), with
// last_char set on the final character of the encoded message, padding
// included. Each byte yields one or two characters, and the final byte up to
// four; while the queue holds entries and out_stall is low the back end
// delivers one character per cycle, a rate that its single output register
// sets.
// With an empty queue the first character of a byte passes through the queue
// entry and then the output register before it is presented.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// url_safe register: 0 selects the standard alphabet with '=' padding, 1
// selects the URL alphabet ('-' and '_') without padding. cfg_ready is always
// high; the register should be written only while no message is in flight.
// Reset clears the phase, the leftover bits, the queue and out_valid, and
// sets the standard alphabet; out_char and last_char are not reset. While
// the receiver holds out_stall the current character stays put, the queue
// fills, and then in_stall rises until characters drain again.

module base64_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       last_char
);

  logic             url_safe;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_not_empty;
  b64e_pkg::entry_t wr_entry;
  b64e_pkg::entry_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_safe <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      url_safe <= cfg_data;
    end
  end

  // Front end: phase tracking and per-byte character planning.
  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .url_safe       (url_safe),
    .in_valid       (in_valid),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .entry          (wr_entry)
  );

  // Queue that decouples the byte side from the character side.
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_entry  (head)
  );

  // Back end: one character per unstalled cycle into the output register.
  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .url_safe    (url_safe),
    .q_not_empty (q_not_empty),
    .head        (head),
    .out_stall   (out_stall),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .last_char   (last_char)
  );

endmodule

### design/b64e_front.sv
// Front end of the base64 encoder: takes bytes, tracks phase and leftover
// bits, and builds one queue entry per byte. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             url_safe,
  input  logic             in_valid,
  input  logic [7:0]       data_byte,
  input  logic             end_of_message,
  input  logic             q_full,
  output logic             in_stall,
  output logic             push,
  output b64e_pkg::entry_t entry
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry         = '0;
    entry.eom     = end_of_message;
    phase_next    = phase;
    leftover_next = leftover;
    unique case (phase)
      b64e_pkg::Phase1: begin
        entry.sym[0]  = {leftover[1:0], data_byte[7:4]};
        leftover_next = data_byte[3:0];
        phase_next    = b64e_pkg::Phase2;
        if (end_of_message) begin
          entry.sym[1]   = {data_byte[3:0], 2'b00};
          entry.pad[2]   = 1'b1;
          entry.last_idx = url_safe ? 2'd1 : 2'd2;
        end
      end
      b64e_pkg::Phase2: begin
        entry.sym[0]   = {leftover, data_byte[7:6]};
        entry.sym[1]   = data_byte[5:0];
        entry.last_idx = 2'd1;
        leftover_next  = 4'd0;
        phase_next     = b64e_pkg::Phase0;
      end
      default: begin
        // The unused phase code behaves like phase zero.
        entry.sym[0]  = data_byte[7:2];
        leftover_next = {2'b00, data_byte[1:0]};
        phase_next    = b64e_pkg::Phase1;
        if (end_of_message) begin
          entry.sym[1]   = {data_byte[1:0], 4'b0000};
          entry.pad[2]   = 1'b1;
          entry.pad[3]   = 1'b1;
          entry.last_idx = url_safe ? 2'd1 : 2'd3;
        end
      end
    endcase
    if (end_of_message) begin
      leftover_next = 4'd0;
      phase_next    = b64e_pkg::Phase0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= b64e_pkg::Phase0;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

### design/b64e_fifo.sv
// Small queue of per-byte entries between the front and back ends.
// Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64e_pkg::entry_t wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output b64e_pkg::entry_t rd_entry
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64e_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = mem[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/b64e_back.sv
// Back end of the base64 encoder: walks the characters of the head entry
// into a registered output, one per unstalled cycle. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             url_safe,
  input  logic             q_not_empty,
  input  b64e_pkg::entry_t head,
  input  logic             out_stall,
  output logic             pop,
  output logic             out_valid,
  output logic [6:0]       out_char,
  output logic             last_char
);

  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       at_end;
  logic [6:0] char_next;

  assign load   = !out_valid || !out_stall;
  assign take   = load && q_not_empty;
  assign at_end = (idx == head.last_idx);
  assign pop    = take && at_end;

  always_comb begin
    if (head.pad[idx]) begin
      char_next = b64e_pkg::ChPad;
    end else begin
      char_next = b64e_pkg::sym_to_ascii(head.sym[idx], url_safe);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (take) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_char  <= char_next;
      last_char <= head.eom && at_end;
    end
  end

endmodule

### test/b64_encode_checker.sv
// Scoreboard for the base64 stream encoder: tracks the message state, predicts
// the characters of each accepted byte and compares them word by word.
// Depends on b64e_pkg for the character constants and phase codes.
`timescale 1ns / 1ps

module b64_encode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [6:0] out_char,
  input  logic       last_char,
  output int         mismatches,
  output int         chars_pending,
  output int         chars_checked
);

  typedef struct packed {
    logic [b64e_pkg::CharW-1:0] code;
    logic                       last;
  } enc_char_t;

  enc_char_t        expected_chars[$];
  enc_char_t        got;
  enc_char_t        want;
  logic             url_mode;
  logic [3:0]       carry_bits;
  logic [1:0]       group_phase;
  int               err_total;
  int               seen_total;

  function automatic logic [b64e_pkg::CharW-1:0] symbol_char(
    input logic [b64e_pkg::SymW-1:0] s,
    input logic url);
    logic [b64e_pkg::CharW-1:0] v;
    v = {1'b0, s};
    if (v < 7'd26) begin
      return b64e_pkg::ChUpperA + v;
    end else if (v < 7'd52) begin
      return b64e_pkg::ChLowerA + v - 7'd26;
    end else if (v < 7'd62) begin
      return b64e_pkg::ChDigit0 + v - 7'd52;
    end else if (v == 7'd62) begin
      return url ? b64e_pkg::ChMinus : b64e_pkg::ChPlus;
    end
    return url ? b64e_pkg::ChUnder : b64e_pkg::ChSlash;
  endfunction

  task automatic queue_code(input logic [b64e_pkg::CharW-1:0] code);
    enc_char_t c;
    c.code = code;
    c.last = 1'b0;
    expected_chars.insert(expected_chars.size(), c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic eom);
    int group_fill;
    group_fill = 0;
    case (group_phase)
      b64e_pkg::Phase1: begin
        queue_code(symbol_char({carry_bits[1:0], b[7:4]}, url_mode));
        carry_bits  = b[3:0];
        group_phase = b64e_pkg::Phase2;
      end
      b64e_pkg::Phase2: begin
        queue_code(symbol_char({carry_bits, b[7:6]}, url_mode));
        queue_code(symbol_char(b[5:0], url_mode));
        carry_bits  = 4'd0;
        group_phase = b64e_pkg::Phase0;
      end
      default: begin
        queue_code(symbol_char(b[7:2], url_mode));
        carry_bits  = {2'b00, b[1:0]};
        group_phase = b64e_pkg::Phase1;
      end
    endcase
    if (eom) begin
      // Flush the pending bits, zero-filled on the right.
      if (group_phase == b64e_pkg::Phase1) begin
        queue_code(symbol_char({carry_bits[1:0], 4'b0000}, url_mode));
        group_fill = 2;
      end else if (group_phase == b64e_pkg::Phase2) begin
        queue_code(symbol_char({carry_bits, 2'b00}, url_mode));
        group_fill = 3;
      end
      if (!url_mode && group_fill != 0) begin
        while (group_fill < 4) begin
          queue_code(b64e_pkg::ChPad);
          group_fill++;
        end
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
      carry_bits  = 4'd0;
      group_phase = b64e_pkg::Phase0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      url_mode    = 1'b0;
      carry_bits  = 4'd0;
      group_phase = b64e_pkg::Phase0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.code = out_char;
        got.last = last_char;
        if (expected_chars.size() == 0) begin
          err_total++;
          $display("%0t: unexpected character, expected none, actual %h last %b",
                   $time, got.code, got.last);
        end else begin
          want = expected_chars.pop_front();
          seen_total++;
          if (got.code !== want.code) begin
            err_total++;
            $display("%0t: out_char mismatch, expected %h actual %h",
                     $time, want.code, got.code);
          end
          if (got.last !== want.last) begin
            err_total++;
            $display("%0t: last_char mismatch, expected %b actual %b",
                     $time, want.last, got.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, end_of_message);
      end
      // A register write applies from the next byte on.
      if (cfg_valid && cfg_ready) begin
        url_mode = cfg_data;
      end
    end
    mismatches    <= err_total;
    chars_pending <= expected_chars.size();
    chars_checked <= seen_total;
  end

endmodule

### test/tb_top.sv
// Top of the base64 stream encoder testbench: clock, reset, byte and
// character stimulus, alphabet register writes, watchdog and verdict.
// Depends on base64_stream_encoder_top and b64_encode_checker.
`timescale 1ns / 1ps

module tb_top;

  // Longest stretch without any word moving before the run is declared hung.
  localparam int WatchdogLimit = 2000;
  localparam int RandomBytes   = 500;
  localparam int DrainCycles   = 10;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic       cfg_data       = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte      = 8'h00;
  logic       end_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [6:0] out_char;
  logic       last_char;

  int          mismatches;
  int          chars_pending;
  int          chars_checked;
  int          bytes_sent;
  int          messages_sent;
  int          cfg_writes;
  int          quiet_cycles;
  int          msg_len;
  int unsigned rx_hold;
  int unsigned rx_draw;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        word_moved;

  always #5 clk = ~clk;

  base64_stream_encoder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .last_char     (last_char)
  );

  b64_encode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .last_char     (last_char),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  // Receiver: after every accepted character it draws a random stall that
  // may be zero. The stall is a plain level, so it may also fall on
  // cycles where the encoder has nothing to offer; calm stretches never stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (out_valid && !out_stall) begin
      rx_draw = rx_calm ? 0 : $urandom_range(0, 14);
      out_stall <= (rx_draw != 0);
      rx_hold   <= rx_draw;
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end
  end

  // Watchdog: any word moved on any channel restarts the count.
  assign word_moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (rst || word_moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d characters still expected",
               $time, WatchdogLimit, chars_pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte after a random gap and holds it until the encoder takes
  // it. The byte and its mark stay put while the word is stalled.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Bytes are packed most significant first; len is 1 to 4.
  task automatic send_fixed_msg(input logic [31:0] bytes, input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_byte(bytes[31 - 8 * i -: 8], i == len - 1);
    end
    messages_sent++;
  endtask

  task automatic send_random_msg(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
    messages_sent++;
  endtask

  // The checker publishes its pending count through a register, so the task
  // lets that register update first; after that an empty store means the
  // encoder is idle, since every byte yields at least one character.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // The alphabet register is only written between messages, with nothing in
  // flight.
  task automatic set_alphabet(input logic url);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= url;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, standard alphabet: one to four byte messages end
    // on each byte phase, so padding of two, one and zero signs is seen. The
    // bytes reach symbols 62 and 63 and the all-zero and all-one extremes.
    set_alphabet(1'b0);
    send_fixed_msg(32'h00_000000, 1);
    send_fixed_msg(32'hFF_80_0000, 2);
    send_fixed_msg(32'hF8_FF_BE_00, 3);
    send_fixed_msg(32'hFB_EF_FF_04, 4);

    // Same shapes in the URL alphabet, where the padding disappears and the
    // two top symbols change character.
    set_alphabet(1'b1);
    send_fixed_msg(32'hFB_000000, 1);
    send_fixed_msg(32'hFC_0F_0000, 2);
    send_fixed_msg(32'hFF_FF_FF_00, 3);
    send_fixed_msg(32'h00_00_00_01, 4);

    // Random part: whole messages of random content, mostly short, a few
    // long ones, with the alphabet switched now and then between messages.
    // Each side runs gap-free for about one message in four, drawn separately.
    msg_len = 0;
    while (bytes_sent < RandomBytes + 20) begin
      if ($urandom_range(0, 4) == 0) begin
        set_alphabet(1'($urandom_range(0, 1)));
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                            : $urandom_range(1, 12);
      send_random_msg(msg_len);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);

    $display("Encoded %0d messages (%0d bytes) into %0d checked characters,",
             messages_sent, bytes_sent, chars_checked);
    $display("with %0d alphabet register writes across both alphabets.", cfg_writes);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
